>>> rtl/emkr_pkg.sv
// Package: shared types, codes and constants for the media key reporter.
`default_nettype none
package emkr_pkg;

    localparam int TIME_BITS = 32;

    // Event kinds
    localparam logic [1:0] MODE_ENC    = 2'd0;
    localparam logic [1:0] MODE_MUTE   = 2'd1;
    localparam logic [1:0] MODE_PAUSE  = 2'd2;
    localparam logic [1:0] MODE_REPORT = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_SPI         = 3'd0;
    localparam logic [2:0] CFG_ENC_DEB     = 3'd1;
    localparam logic [2:0] CFG_RPT_IVL     = 3'd2;
    localparam logic [2:0] CFG_REL_DLY     = 3'd3;
    localparam logic [2:0] CFG_BTN_DEB     = 3'd4;

    localparam int CFG_DATA_BITS = 22;

    // Consumer usage codes
    localparam logic [15:0] USAGE_VOL_UP     = 16'h00E9;
    localparam logic [15:0] USAGE_VOL_DOWN   = 16'h00EA;
    localparam logic [15:0] USAGE_PLAY_PAUSE = 16'h00CD;
    localparam logic [15:0] USAGE_MUTE       = 16'h00E2;
    localparam logic [15:0] USAGE_RELEASE    = 16'h0000;

    // Reset values of the configuration registers
    localparam logic [4:0]  RST_SPI     = 5'd4;
    localparam logic [19:0] RST_ENC_DEB = 20'd1000;
    localparam logic [19:0] RST_RPT_IVL = 20'd20000;
    localparam logic [19:0] RST_REL_DLY = 20'd10000;
    localparam logic [21:0] RST_BTN_DEB = 22'd50000;

    typedef struct packed {
        logic [4:0]  steps_per_indent;
        logic [19:0] encoder_debounce_us;
        logic [19:0] report_interval_us;
        logic [19:0] release_delay_us;
        logic [21:0] button_debounce_us;
    } t_cfg;

    typedef struct packed {
        logic [1:0]           mode;
        logic                 enc_a;
        logic                 enc_b;
        logic [TIME_BITS-1:0] now;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [15:0] code;
    } t_result;

endpackage
`default_nettype wire

>>> rtl/emkr_core.sv
// Event processing core: encoder, button and report state, updated on each fired item.
`default_nettype none
module emkr_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire emkr_pkg::t_item  i_item,
    input  wire emkr_pkg::t_cfg   i_cfg,
    output emkr_pkg::t_result     o_result
);

    localparam int TB = emkr_pkg::TIME_BITS;
    // compare width: wide enough for both a time difference and any register
    localparam int CW = (TB > emkr_pkg::CFG_DATA_BITS) ? TB : emkr_pkg::CFG_DATA_BITS;

    logic [1:0]          r_last_phase,       n_last_phase;
    logic [TB-1:0]       r_last_step_time,   n_last_step_time;
    logic signed [6:0]   r_step_delta,       n_step_delta;
    logic [TB-1:0]       r_last_report_time, n_last_report_time;
    logic [TB-1:0]       r_last_pause_time,  n_last_pause_time;
    logic [TB-1:0]       r_last_button_time, n_last_button_time;
    logic                r_mute_pending,     n_mute_pending;
    logic                r_pause_pending,    n_pause_pending;
    logic                r_key_held,         n_key_held;

    logic [4:0]          spi;
    logic signed [6:0]   spi_s;
    logic signed [6:0]   limit_s;
    logic [TB-1:0]       el_step, el_report, el_pause, el_button;
    logic [1:0]          phase;
    logic [1:0]          pos_from, pos_to, pos_d;
    logic signed [6:0]   stepped;
    logic                res_valid;
    logic [15:0]         res_code;

    always_comb begin
        if (i_cfg.steps_per_indent == 5'd0) begin
            spi = 5'd1;
        end else if (i_cfg.steps_per_indent > 5'd16) begin
            spi = 5'd16;
        end else begin
            spi = i_cfg.steps_per_indent;
        end
    end

    assign spi_s   = $signed({2'b00, spi});
    assign limit_s = spi_s + (spi_s <<< 1);

    // Wrapping time differences
    assign el_step   = i_item.now - r_last_step_time;
    assign el_report = i_item.now - r_last_report_time;
    assign el_pause  = i_item.now - r_last_pause_time;
    assign el_button = i_item.now - r_last_button_time;

    // Gray position: 00->0, 01->1, 11->2, 10->3
    assign phase    = {i_item.enc_a, i_item.enc_b};
    assign pos_from = {r_last_phase[1], r_last_phase[1] ^ r_last_phase[0]};
    assign pos_to   = {phase[1], phase[1] ^ phase[0]};
    assign pos_d    = pos_to - pos_from;

    always_comb begin
        n_last_phase       = r_last_phase;
        n_last_step_time   = r_last_step_time;
        n_step_delta       = r_step_delta;
        n_last_report_time = r_last_report_time;
        n_last_pause_time  = r_last_pause_time;
        n_last_button_time = r_last_button_time;
        n_mute_pending     = r_mute_pending;
        n_pause_pending    = r_pause_pending;
        n_key_held         = r_key_held;
        res_valid          = 1'b0;
        res_code           = emkr_pkg::USAGE_RELEASE;
        stepped            = r_step_delta;

        case (i_item.mode)
            emkr_pkg::MODE_ENC: begin
                if (CW'(el_step) >= CW'(i_cfg.encoder_debounce_us)) begin
                    if (phase != r_last_phase) begin
                        if (pos_d == 2'd1) begin
                            stepped = r_step_delta - 7'sd1;
                        end else if (pos_d == 2'd3) begin
                            stepped = r_step_delta + 7'sd1;
                        end
                        n_last_phase     = phase;
                        n_last_step_time = i_item.now;
                    end
                    // clamp also applies when the phase did not move
                    if (stepped > limit_s) begin
                        n_step_delta = limit_s;
                    end else if (stepped < -limit_s) begin
                        n_step_delta = -limit_s;
                    end else begin
                        n_step_delta = stepped;
                    end
                end
            end
            emkr_pkg::MODE_MUTE: begin
                if (CW'(el_button) > CW'(i_cfg.button_debounce_us)) begin
                    n_mute_pending     = 1'b1;
                    n_last_button_time = i_item.now;
                end
            end
            emkr_pkg::MODE_PAUSE: begin
                n_pause_pending = 1'b1;
            end
            emkr_pkg::MODE_REPORT: begin
                if (r_step_delta >= spi_s) begin
                    if (CW'(el_report) > CW'(i_cfg.report_interval_us)) begin
                        n_step_delta = r_step_delta - spi_s;
                        res_valid    = 1'b1;
                        res_code     = emkr_pkg::USAGE_VOL_UP;
                    end
                end else if (r_step_delta <= -spi_s) begin
                    if (CW'(el_report) > CW'(i_cfg.report_interval_us)) begin
                        n_step_delta = r_step_delta + spi_s;
                        res_valid    = 1'b1;
                        res_code     = emkr_pkg::USAGE_VOL_DOWN;
                    end
                end else if (r_pause_pending) begin
                    if (CW'(el_pause) > CW'(i_cfg.button_debounce_us)) begin
                        n_pause_pending   = 1'b0;
                        n_last_pause_time = i_item.now;
                        res_valid         = 1'b1;
                        res_code          = emkr_pkg::USAGE_PLAY_PAUSE;
                    end
                end else if (r_mute_pending) begin
                    n_mute_pending = 1'b0;
                    res_valid      = 1'b1;
                    res_code       = emkr_pkg::USAGE_MUTE;
                end else if (r_key_held && (CW'(el_report) > CW'(i_cfg.release_delay_us))) begin
                    res_valid = 1'b1;
                    res_code  = emkr_pkg::USAGE_RELEASE;
                end
                if (res_valid) begin
                    n_last_report_time = i_item.now;
                    n_key_held         = (res_code != emkr_pkg::USAGE_RELEASE);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_phase       <= '0;
            r_last_step_time   <= '0;
            r_step_delta       <= '0;
            r_last_report_time <= '0;
            r_last_pause_time  <= '0;
            r_last_button_time <= '0;
            r_mute_pending     <= 1'b0;
            r_pause_pending    <= 1'b0;
            r_key_held         <= 1'b0;
        end else if (i_fire) begin
            r_last_phase       <= n_last_phase;
            r_last_step_time   <= n_last_step_time;
            r_step_delta       <= n_step_delta;
            r_last_report_time <= n_last_report_time;
            r_last_pause_time  <= n_last_pause_time;
            r_last_button_time <= n_last_button_time;
            r_mute_pending     <= n_mute_pending;
            r_pause_pending    <= n_pause_pending;
            r_key_held         <= n_key_held;
        end
    end

    assign o_result.valid = res_valid;
    assign o_result.code  = res_code;

endmodule
`default_nettype wire

>>> rtl/encoder_media_key_reporter.sv
// Top level: media key reporter with input register, core and skid-buffered output.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | mode, enc_a, enc_b, now_us
//  out     | source    | o_out_valid / i_out_stall | usage_code
//  cfg     | sink      | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while the skid entry stays empty; a result reaches
// o_out_valid through the input register, then the output register.
// Synchronous active-low reset clears all control state and config to defaults.
// A two-entry output (register plus skid) lets input keep flowing while out stalls;
// o_in_stall rises only when both output entries are full and an item is waiting.
`default_nettype none
module encoder_media_key_reporter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_in_mode,
    input  wire logic        i_in_enc_a,
    input  wire logic        i_in_enc_b,
    input  wire logic [31:0] i_in_now_us,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_out_usage_code,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [emkr_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);

    emkr_pkg::t_cfg    r_cfg;
    emkr_pkg::t_item   r_item;
    logic              r_in_valid;
    logic              r_out_valid;
    logic [15:0]       r_out_code;
    logic              r_skid_valid;
    logic [15:0]       r_skid_code;
    emkr_pkg::t_result result;
    logic              fire;
    logic              deq;
    logic              in_acc;

    // Config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.steps_per_indent    <= emkr_pkg::RST_SPI;
            r_cfg.encoder_debounce_us <= emkr_pkg::RST_ENC_DEB;
            r_cfg.report_interval_us  <= emkr_pkg::RST_RPT_IVL;
            r_cfg.release_delay_us    <= emkr_pkg::RST_REL_DLY;
            r_cfg.button_debounce_us  <= emkr_pkg::RST_BTN_DEB;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                emkr_pkg::CFG_SPI:     r_cfg.steps_per_indent    <= i_cfg_data[4:0];
                emkr_pkg::CFG_ENC_DEB: r_cfg.encoder_debounce_us <= i_cfg_data[19:0];
                emkr_pkg::CFG_RPT_IVL: r_cfg.report_interval_us  <= i_cfg_data[19:0];
                emkr_pkg::CFG_REL_DLY: r_cfg.release_delay_us    <= i_cfg_data[19:0];
                emkr_pkg::CFG_BTN_DEB: r_cfg.button_debounce_us  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Process the held item whenever the skid entry is free: there is always
    // room for its result in either the output register or the skid.
    assign fire       = r_in_valid && !r_skid_valid;
    assign o_in_stall = r_in_valid && r_skid_valid;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign deq        = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.mode  <= i_in_mode;
            r_item.enc_a <= i_in_enc_a;
            r_item.enc_b <= i_in_enc_b;
            r_item.now   <= emkr_pkg::TIME_BITS'(i_in_now_us);
        end
    end

    emkr_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    // Output register plus skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (deq) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || deq) begin
            r_out_valid <= fire && result.valid;
        end else if (fire && result.valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (deq) begin
                r_out_code <= r_skid_code;
            end
        end else if (!r_out_valid || deq) begin
            r_out_code <= result.code;
        end else begin
            r_skid_code <= result.code;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_usage_code = r_out_code;

endmodule
`default_nettype wire

>>> tb/emkr_tb_pkg.sv
// Scoreboard class: predicts media key usage codes and checks the DUT output stream.
package emkr_tb_pkg;
    import emkr_pkg::*;

    class usage_scoreboard;
        // register copies, raw widths as written
        logic [4:0]  spi;
        logic [19:0] enc_deb;
        logic [19:0] rpt_ivl;
        logic [19:0] rel_dly;
        logic [21:0] btn_deb;

        // predictor state
        logic [1:0]  last_phase;
        logic [31:0] step_t;
        logic [31:0] report_t;
        logic [31:0] pause_t;
        logic [31:0] button_t;
        int          delta;
        bit          mute_pend;
        bit          pause_pend;
        bit          key_held;

        logic [15:0] codes_due[$];
        int          err_count;

        function new();
            spi        = RST_SPI;
            enc_deb    = RST_ENC_DEB;
            rpt_ivl    = RST_RPT_IVL;
            rel_dly    = RST_REL_DLY;
            btn_deb    = RST_BTN_DEB;
            last_phase = 2'b00;
            step_t     = '0;
            report_t   = '0;
            pause_t    = '0;
            button_t   = '0;
            delta      = 0;
            mute_pend  = 1'b0;
            pause_pend = 1'b0;
            key_held   = 1'b0;
            err_count  = 0;
        endfunction

        // Gray phase <-> position along 00,01,11,10 (the mapping is its own inverse)
        function logic [1:0] gray_swap(logic [1:0] p);
            return {p[1], p[1] ^ p[0]};
        endfunction

        function int gray_dir(logic [1:0] from_ph, logic [1:0] to_ph);
            logic [1:0] d;
            d = gray_swap(to_ph) - gray_swap(from_ph);
            if (d == 2'd1) return -1;
            if (d == 2'd3) return 1;
            return 0;
        endfunction

        function logic [31:0] us_since(logic [31:0] then_us, logic [31:0] now_us);
            return now_us - then_us;
        endfunction

        // zero behaves as one, anything above sixteen as sixteen
        function int eff_spi();
            if (spi == 5'd0) return 1;
            if (spi > 5'd16) return 16;
            return int'(spi);
        endfunction

        function void write_reg(logic [2:0] idx, logic [21:0] d);
            case (idx)
                CFG_SPI:     spi     = d[4:0];
                CFG_ENC_DEB: enc_deb = d[19:0];
                CFG_RPT_IVL: rpt_ivl = d[19:0];
                CFG_REL_DLY: rel_dly = d[19:0];
                CFG_BTN_DEB: btn_deb = d[21:0];
                default: ;
            endcase
        endfunction

        // Applies one accepted input transaction; returns 1 on a phase move, a button request or a sent code.
        function bit note_event(logic [1:0] mode, logic a, logic b, logic [31:0] now_us);
            logic [1:0]  ph;
            logic [15:0] code;
            bit          sent;
            bit          effect;
            int          spi_n;
            int          lim;
            spi_n  = eff_spi();
            lim    = 3 * spi_n;
            sent   = 1'b0;
            effect = 1'b0;
            code   = USAGE_RELEASE;
            case (mode)
                MODE_ENC: begin
                    if (us_since(step_t, now_us) >= enc_deb) begin
                        ph = {a, b};
                        if (ph != last_phase) begin
                            delta += gray_dir(last_phase, ph);
                            last_phase = ph;
                            step_t = now_us;
                            effect = 1'b1;
                        end
                        if (delta > lim) delta = lim;
                        else if (delta < -lim) delta = -lim;
                    end
                end
                MODE_MUTE: begin
                    if (us_since(button_t, now_us) > btn_deb) begin
                        mute_pend = 1'b1;
                        button_t = now_us;
                        effect = 1'b1;
                    end
                end
                MODE_PAUSE: begin
                    pause_pend = 1'b1;
                    effect = 1'b1;
                end
                MODE_REPORT: begin
                    if (delta >= spi_n) begin
                        if (us_since(report_t, now_us) > rpt_ivl) begin
                            delta -= spi_n;
                            code = USAGE_VOL_UP;
                            sent = 1'b1;
                        end
                    end else if (delta <= -spi_n) begin
                        if (us_since(report_t, now_us) > rpt_ivl) begin
                            delta += spi_n;
                            code = USAGE_VOL_DOWN;
                            sent = 1'b1;
                        end
                    end else if (pause_pend) begin
                        if (us_since(pause_t, now_us) > btn_deb) begin
                            pause_pend = 1'b0;
                            pause_t = now_us;
                            code = USAGE_PLAY_PAUSE;
                            sent = 1'b1;
                        end
                    end else if (mute_pend) begin
                        mute_pend = 1'b0;
                        code = USAGE_MUTE;
                        sent = 1'b1;
                    end else if (key_held && us_since(report_t, now_us) > rel_dly) begin
                        code = USAGE_RELEASE;
                        sent = 1'b1;
                    end
                    if (sent) begin
                        report_t = now_us;
                        key_held = (code != USAGE_RELEASE);
                        codes_due.push_back(code);
                    end
                    effect = sent;
                end
                default: ;
            endcase
            return effect;
        endfunction

        task flag(string msg);
            err_count++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_usage(logic [15:0] code);
            logic [15:0] want;
            if (codes_due.size() == 0) begin
                flag($sformatf("usage code %h with nothing expected", code));
            end else begin
                want = codes_due.pop_front();
                if (code !== want)
                    flag($sformatf("usage code %h, expected %h", code, want));
            end
        endtask
    endclass

endpackage

>>> tb/encoder_media_key_reporter_test.sv
// Testbench top: stimulus, handshakes and checking for the media key reporter.
module encoder_media_key_reporter_test;
    import emkr_pkg::*;
    import emkr_tb_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_in_mode;
    logic        i_in_enc_a;
    logic        i_in_enc_b;
    logic [31:0] i_in_now_us;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_out_usage_code;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    usage_scoreboard sb;

    // Stimulus-side knobs: gaps_on lets the sender idle, stall_on lets the
    // receiver stall. Both are reshuffled per burst so quiet stretches exist too.
    bit          gaps_on;
    bit          stall_on;
    bit          quiet;
    int          effective_items;
    int          stall_left;
    logic [31:0] tb_us;     // running microsecond clock for well-formed sequences

    encoder_media_key_reporter u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_in_mode        (i_in_mode),
        .i_in_enc_a       (i_in_enc_a),
        .i_in_enc_b       (i_in_enc_b),
        .i_in_now_us      (i_in_now_us),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_usage_code (o_out_usage_code),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // Hard stop if the run hangs (e.g. a result that never shows up).
    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("encoder_media_key_reporter_test: errors");
        $finish;
    end

    // Receiver: random stall bursts while stall_on is set.
    always @(posedge i_clk) begin
        if (!stall_on) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 10);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Output side: every accepted transaction is checked against the oldest
    // predicted usage code. Values read here are the pre-edge ones.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && !i_out_stall)
            sb.check_usage(o_out_usage_code);
    end

    // Gap around a threshold: exactly on it, one past, one short, at or below,
    // above, tiny, or well beyond.
    function automatic logic [31:0] pick_gap(int lim);
        case ($urandom_range(0, 6))
            0: return lim;
            1: return lim + 1;
            2: return (lim == 0) ? 0 : lim - 1;
            3: return $urandom_range(0, lim);
            4: return lim + $urandom_range(2, 5000);
            5: return $urandom_range(0, 20);
            default: return 2 * lim + 1;
        endcase
    endfunction

    // Present one item, hold it until accepted, then feed the predictor.
    // Valid only drops inside the optional idle burst, never in the
    // same step it goes high again.
    task automatic send_item(logic [1:0] mode, logic a, logic b, logic [31:0] now_us);
        if (gaps_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_mode   <= mode;
        i_in_enc_a  <= a;
        i_in_enc_b  <= b;
        i_in_now_us <= now_us;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        void'(sb.note_event(mode, a, b, now_us));
        effective_items++;
    endtask

    // Stop sending and let every predicted code come out. Items that make no
    // result may still sit in the two-stage pipe, so wait for them to clear too.
    task automatic wait_all_reported();
        i_in_valid <= 1'b0;
        while (sb.codes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all five registers on an idle block. Unused upper data bits get
    // random junk half the time; the block must ignore them.
    task automatic program_regs(logic [4:0] spi_v, logic [19:0] enc_v, logic [19:0] rpt_v,
                                logic [19:0] rel_v, logic [21:0] btn_v);
        logic [21:0] junk;
        logic [21:0] word [5];
        logic [2:0]  reg_idx [5];
        int          k;
        junk = ($urandom_range(0, 1) == 1) ? 22'($urandom) : '0;
        word[0] = {junk[21:5], spi_v};
        word[1] = {junk[21:20], enc_v};
        word[2] = {junk[21:20], rpt_v};
        word[3] = {junk[21:20], rel_v};
        word[4] = btn_v;
        reg_idx = '{CFG_SPI, CFG_ENC_DEB, CFG_RPT_IVL, CFG_REL_DLY, CFG_BTN_DEB};
        wait_all_reported();
        for (k = 0; k < 5; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= reg_idx[k];
            i_cfg_data  <= word[k];
            @(posedge i_clk);
            sb.write_reg(reg_idx[k], word[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    // Knob turned one way for a run of detents, with the odd contact bounce
    // or skipped phase, followed by report slots to drain the delta.
    task automatic rotation_burst();
        int         n;
        int         k;
        bit         up;
        logic [1:0] pos;
        logic [1:0] ph;
        n  = $urandom_range(1, 3 * sb.eff_spi() + 4);
        up = $urandom_range(0, 1);
        for (k = 0; k < n; k++) begin
            pos = sb.gray_swap(sb.last_phase);
            case ($urandom_range(0, 19))
                0: begin    // bounce inside the debounce window
                    tb_us += $urandom_range(0, int'(sb.enc_deb));
                    ph = 2'($urandom);
                end
                1: begin    // illegal two-phase jump
                    tb_us += sb.enc_deb + $urandom_range(0, 50);
                    ph = sb.gray_swap(pos + 2'd2);
                end
                default: begin
                    tb_us += sb.enc_deb + (($urandom_range(0, 3) == 0) ? 0 :
                             $urandom_range(1, 300));
                    ph = sb.gray_swap(up ? pos - 2'd1 : pos + 2'd1);
                end
            endcase
            send_item(MODE_ENC, ph[1], ph[0], tb_us);
        end
        repeat ($urandom_range(1, 5)) begin
            tb_us += pick_gap(($urandom_range(0, 2) == 0) ? int'(sb.rel_dly) :
                              int'(sb.rpt_ivl));
            send_item(MODE_REPORT, 1'($urandom), 1'($urandom), tb_us);
        end
    endtask

    // Mute edges, pause requests and report slots around their windows.
    task automatic button_burst();
        int lim;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 3))
                0: begin
                    tb_us += pick_gap(int'(sb.btn_deb));
                    send_item(MODE_MUTE, 1'($urandom), 1'($urandom), tb_us);
                end
                1: begin
                    tb_us += $urandom_range(0, 100);
                    send_item(MODE_PAUSE, 1'($urandom), 1'($urandom), tb_us);
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0:       lim = int'(sb.rpt_ivl);
                        1:       lim = int'(sb.rel_dly);
                        default: lim = int'(sb.btn_deb);
                    endcase
                    tb_us += pick_gap(lim);
                    send_item(MODE_REPORT, 1'($urandom), 1'($urandom), tb_us);
                end
            endcase
        end
    endtask

    // Anything at all: random kind, levels and timestamp.
    task automatic noise_items();
        logic [31:0] stamp;
        repeat ($urandom_range(1, 3)) begin
            stamp = $urandom;
            if ($urandom_range(0, 1) == 1) tb_us = stamp;
            send_item(2'($urandom), 1'($urandom), 1'($urandom), stamp);
        end
    endtask

    task automatic run_phase(int target);
        int start;
        start = effective_items;
        while (effective_items - start < target) begin
            if (!quiet) begin
                gaps_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: rotation_burst();
                5, 6, 7:       button_burst();
                default:       noise_items();
            endcase
        end
    endtask

    initial begin
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_mode   <= MODE_ENC;
        i_in_enc_a  <= 1'b0;
        i_in_enc_b  <= 1'b0;
        i_in_now_us <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_SPI;
        i_cfg_data  <= '0;
        gaps_on = 1'b0;
        stall_on = 1'b0;
        quiet = 1'b0;
        effective_items = 0;
        tb_us = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass on reset settings: one indent per four quarter steps,
        // debounce / interval / release / button windows hit on their edges.
        stall_on = 1'b1;
        send_item(MODE_REPORT, 1'b0, 1'b0, 32'd0);       // nothing held: silent
        send_item(MODE_ENC, 1'b0, 1'b1, 32'd999);        // inside encoder debounce
        send_item(MODE_ENC, 1'b0, 1'b1, 32'd1000);       // four steps, down direction
        send_item(MODE_ENC, 1'b1, 1'b1, 32'd2000);
        send_item(MODE_ENC, 1'b1, 1'b0, 32'd3000);
        send_item(MODE_ENC, 1'b0, 1'b0, 32'd4000);
        send_item(MODE_ENC, 1'b1, 1'b1, 32'd5000);       // two-phase jump, no count
        send_item(MODE_REPORT, 1'b1, 1'b1, 32'd20000);   // interval not yet exceeded
        send_item(MODE_REPORT, 1'b0, 1'b0, 32'd20001);   // volume down
        send_item(MODE_REPORT, 1'b0, 1'b0, 32'd30001);   // release delay not exceeded
        send_item(MODE_REPORT, 1'b0, 1'b0, 32'd30002);   // release
        send_item(MODE_PAUSE, 1'b1, 1'b1, 32'd30002);
        send_item(MODE_MUTE, 1'b0, 1'b1, 32'd50000);     // on the button window: ignored
        send_item(MODE_MUTE, 1'b1, 1'b0, 32'd50001);
        send_item(MODE_REPORT, 1'b0, 1'b0, 32'd50001);   // play/pause beats mute
        send_item(MODE_REPORT, 1'b0, 1'b0, 32'd50001);   // then mute
        send_item(MODE_PAUSE, 1'b0, 1'b0, 32'd50001);
        send_item(MODE_REPORT, 1'b0, 1'b0, 32'd50001);   // pause held back by debounce
        send_item(MODE_ENC, 1'b1, 1'b0, 32'hFFFF_FFFF);  // top of the timestamp range
        send_item(MODE_ENC, 1'b0, 1'b0, 32'h0000_0000);  // wrapped, still debounced
        send_item(MODE_ENC, 1'b0, 1'b0, 32'd999);        // wrapped difference of 1000
        send_item(MODE_REPORT, 1'b1, 1'b1, 32'd999);     // pause window across the wrap
        tb_us = 32'd1000;

        // Random phases, each on a fresh register setting. Every switch
        // drains the pipe first, so the sender sits idle until all is out.
        program_regs(5'd1, 20'd0, 20'd0, 20'd0, 22'd0);
        run_phase(PHASE_ITEMS);
        program_regs(5'd16, RST_ENC_DEB, RST_RPT_IVL, RST_REL_DLY, RST_BTN_DEB);
        run_phase(PHASE_ITEMS);
        program_regs(5'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 22'h3FFFFF);
        run_phase(PHASE_ITEMS);
        program_regs(5'd31, 20'($urandom_range(0, 3000)), 20'($urandom_range(0, 60000)),
                     20'($urandom_range(0, 30000)), 22'($urandom_range(0, 100000)));
        run_phase(PHASE_ITEMS);
        program_regs(5'($urandom_range(1, 16)), 20'($urandom_range(0, 500)),
                     20'($urandom_range(0, 5000)), 20'($urandom_range(0, 5000)),
                     22'($urandom_range(0, 8000)));
        tb_us = 32'hFFF0_0000;      // run the clock through its wrap
        run_phase(PHASE_ITEMS);

        // Last stretch at full rate: no sender gaps, no receiver stalls.
        program_regs(RST_SPI, RST_ENC_DEB, RST_RPT_IVL, RST_REL_DLY, RST_BTN_DEB);
        quiet = 1'b1;
        gaps_on = 1'b0;
        stall_on = 1'b0;
        run_phase(PHASE_ITEMS);

        wait_all_reported();
        repeat (8) @(posedge i_clk);
        if (sb.err_count == 0 && sb.codes_due.size() == 0)
            $display("encoder_media_key_reporter_test: clean");
        else
            $display("encoder_media_key_reporter_test: errors");
        $finish;
    end

endmodule

>>> sim.f
rtl/emkr_pkg.sv
rtl/emkr_core.sv
rtl/encoder_media_key_reporter.sv
tb/emkr_tb_pkg.sv
tb/encoder_media_key_reporter_test.sv
